[design/twisp_pkg.sv]
// Package for the two-wire programming link master.
// Holds the operation and action codes, shared structs and reset constants.
// No dependencies.
`default_nettype none

package twisp_pkg;

    // command codes as carried on the action field
    typedef enum logic [2:0] {
        ACT_TICK  = 3'd0,
        ACT_START = 3'd1,
        ACT_WRITE = 3'd2,
        ACT_READ  = 3'd3,
        ACT_END   = 3'd4
    } action_t;

    // operation in progress
    typedef enum logic [2:0] {
        OP_IDLE  = 3'd0,
        OP_START = 3'd1,
        OP_WRITE = 3'd2,
        OP_READ  = 3'd3,
        OP_END   = 3'd4
    } op_t;

    localparam int unsigned HALF_W       = 8;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned PHASE_W      = 5;
    localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 8'd2;

    // phase counts per operation
    localparam logic [PHASE_W-1:0] START_PHASES = 5'd4;
    localparam logic [PHASE_W-1:0] XFER_PHASES  = 5'd17;
    localparam logic [PHASE_W-1:0] END_PHASES   = 5'd3;
    localparam logic [PHASE_W-1:0] BIT_PHASES   = 5'd16;

    // one result transaction
    typedef struct packed {
        logic              clk_level;
        logic              sda_level;
        logic              sda_drive;
        logic              busy_res;
        logic              done_res;
        logic              refused;
        logic [BYTE_W-1:0] rx_byte;
    } result_t;

    // pin and shift state touched by the phase table
    typedef struct packed {
        logic [BYTE_W-1:0] shift;
        logic              clk;
        logic              sda;
        logic              drive;
        logic [BYTE_W-1:0] rx;
    } pin_state_t;

endpackage

`default_nettype wire

[design/two_wire_isp_frame_master_unit.sv]
// Top level of the two-wire programming link master.
// Holds the half period register and the result register; instantiates twisp_core.
// Depends on twisp_pkg and twisp_core.
`default_nettype none

// Each input transaction (a tick or a command) is taken by the sequencer and
// its result appears in the result register on the next cycle, so one
// transaction per cycle is sustained while the output side keeps taking
// results. The single result register sets that figure: a new transaction is
// taken whenever that register is empty or is being emptied in the same cycle.
// Pin phases are timed in ticks, not clock cycles: each phase is held for
// half_period_ticks tick transactions (zero behaves as one). A start takes 4
// phases, a byte write or read 17, an end 3. Commands sent while an operation
// is in progress are refused and do not count as ticks. The half period
// register is written through cfg_valid/cfg_data, is always ready and resets to 2.

module two_wire_isp_frame_master_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration write channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [twisp_pkg::HALF_W-1:0]   cfg_data,
    // input channel
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [2:0]                     action,
    input  wire logic [twisp_pkg::BYTE_W-1:0]   tx_byte,
    input  wire logic                           sda_in,
    // result channel
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                clk_level,
    output logic                                sda_level,
    output logic                                sda_drive,
    output logic                                busy_res,
    output logic                                done_res,
    output logic                                refused,
    output logic [twisp_pkg::BYTE_W-1:0]        rx_byte
);

    logic [twisp_pkg::HALF_W-1:0]   half_reg;
    logic                           out_valid_reg, out_valid_next;
    twisp_pkg::result_t             res_reg;
    twisp_pkg::result_t             res_step;
    logic                           in_accept;

    // handshake
    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= twisp_pkg::HALF_PERIOD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            half_reg <= cfg_data;
        end
    end

    // sequencer
    twisp_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (in_accept),
        .action      (action),
        .tx_byte     (tx_byte),
        .sda_in      (sda_in),
        .half_period (half_reg),
        .res         (res_step)
    );

    // result register occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            res_reg <= res_step;
        end
    end

    assign out_valid = out_valid_reg;
    assign clk_level = res_reg.clk_level;
    assign sda_level = res_reg.sda_level;
    assign sda_drive = res_reg.sda_drive;
    assign busy_res  = res_reg.busy_res;
    assign done_res  = res_reg.done_res;
    assign refused   = res_reg.refused;
    assign rx_byte   = res_reg.rx_byte;

    // every accepted transaction leaves a result waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted transaction produced no result");

    // a waiting result stays put until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(res_reg)))
        else $error("waiting result changed before it was taken");

    // an empty result register never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input blocked with the result register empty");

endmodule

`default_nettype wire

[design/twisp_core.sv]
// Phase sequencer of the two-wire programming link master.
// Holds the operation, phase, tick and pin state; one step per transaction.
// Depends on twisp_pkg.
`default_nettype none

module twisp_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           step_en,
    input  wire logic [2:0]                     action,
    input  wire logic [twisp_pkg::BYTE_W-1:0]   tx_byte,
    input  wire logic                           sda_in,
    input  wire logic [twisp_pkg::HALF_W-1:0]   half_period,
    output twisp_pkg::result_t                  res
);

    // phases held by each operation
    function automatic logic [twisp_pkg::PHASE_W-1:0] held_phases(input twisp_pkg::op_t op);
        logic [twisp_pkg::PHASE_W-1:0] n;
        unique case (op)
            twisp_pkg::OP_START: n = twisp_pkg::START_PHASES;
            twisp_pkg::OP_WRITE: n = twisp_pkg::XFER_PHASES;
            twisp_pkg::OP_READ:  n = twisp_pkg::XFER_PHASES;
            twisp_pkg::OP_END:   n = twisp_pkg::END_PHASES;
            default:             n = '0;
        endcase
        return n;
    endfunction

    // pin update on entry to a phase
    function automatic twisp_pkg::pin_state_t enter_phase(
        input twisp_pkg::op_t                   op,
        input logic [twisp_pkg::PHASE_W-1:0]    idx,
        input logic                             bit_in,
        input twisp_pkg::pin_state_t            s_in
    );
        twisp_pkg::pin_state_t s;
        s = s_in;
        unique case (op)
            twisp_pkg::OP_START: begin
                case (idx)
                    5'd0:    s.sda = 1'b1;
                    5'd1:    s.clk = 1'b1;
                    5'd2:    s.sda = 1'b0;
                    5'd3:    s.clk = 1'b0;
                    default: s = s_in;
                endcase
            end
            twisp_pkg::OP_WRITE: begin
                if (idx < twisp_pkg::BIT_PHASES)
                begin
                    if (!idx[0])
                    begin
                        if (idx != '0)
                        begin
                            s.shift = {s.shift[twisp_pkg::BYTE_W-2:0], 1'b0};
                        end
                        s.clk = 1'b0;
                        s.sda = s.shift[twisp_pkg::BYTE_W-1];
                    end
                    else
                    begin
                        s.clk = 1'b1;
                    end
                end
                else if (idx == twisp_pkg::BIT_PHASES)
                begin
                    s.clk = 1'b0;
                end
                else
                begin
                    s.sda = 1'b0;
                end
            end
            twisp_pkg::OP_READ: begin
                if (idx < twisp_pkg::BIT_PHASES)
                begin
                    if (!idx[0])
                    begin
                        s.clk = 1'b0;
                    end
                    else
                    begin
                        s.clk   = 1'b1;
                        s.shift = {s.shift[twisp_pkg::BYTE_W-2:0], bit_in};
                    end
                end
                else if (idx == twisp_pkg::BIT_PHASES)
                begin
                    s.clk = 1'b0;
                end
                else
                begin
                    s.drive = 1'b1;
                    s.sda   = 1'b0;
                    s.rx    = s.shift;
                end
            end
            twisp_pkg::OP_END: begin
                case (idx)
                    5'd0:    s.clk = 1'b0;
                    5'd1:    s.sda = 1'b0;
                    5'd2:    s.clk = 1'b1;
                    default: s.sda = 1'b1;
                endcase
            end
            default: s = s_in;
        endcase
        return s;
    endfunction

    twisp_pkg::op_t                   op_reg, op_next;
    logic [twisp_pkg::PHASE_W-1:0]    phase_reg, phase_next;
    logic [twisp_pkg::HALF_W-1:0]     tick_reg, tick_next;
    twisp_pkg::pin_state_t            pins_reg, pins_next;

    twisp_pkg::action_t               act;
    logic                             is_cmd;
    logic                             is_tick;
    logic                             busy;
    logic [twisp_pkg::HALF_W-1:0]     tick_inc;
    logic                             phase_end;
    logic [twisp_pkg::PHASE_W-1:0]    phase_inc;
    logic                             op_last;
    twisp_pkg::op_t                   op_cmd;
    twisp_pkg::pin_state_t            pins_pre;
    logic                             refused_c;
    logic                             done_c;

    // decode of the incoming transaction
    assign act       = twisp_pkg::action_t'(action);
    assign is_cmd    = act inside {twisp_pkg::ACT_START, twisp_pkg::ACT_WRITE,
                                   twisp_pkg::ACT_READ, twisp_pkg::ACT_END};
    assign is_tick   = (act == twisp_pkg::ACT_TICK);
    assign busy      = (op_reg != twisp_pkg::OP_IDLE);
    assign tick_inc  = tick_reg + 1'b1;
    assign phase_end = (tick_inc >= half_period);
    assign phase_inc = phase_reg + 1'b1;
    assign op_last   = (phase_inc >= held_phases(op_reg));
    assign refused_c = is_cmd && busy;
    assign done_c    = is_tick && busy && phase_end && op_last;

    // operation selected by a command
    always_comb
    begin
        unique case (act)
            twisp_pkg::ACT_START: op_cmd = twisp_pkg::OP_START;
            twisp_pkg::ACT_WRITE: op_cmd = twisp_pkg::OP_WRITE;
            twisp_pkg::ACT_READ:  op_cmd = twisp_pkg::OP_READ;
            twisp_pkg::ACT_END:   op_cmd = twisp_pkg::OP_END;
            default:              op_cmd = twisp_pkg::OP_IDLE;
        endcase
    end

    // next operation
    always_comb
    begin
        op_next = op_reg;
        if (is_cmd && !busy)
        begin
            op_next = op_cmd;
        end
        else if (done_c)
        begin
            op_next = twisp_pkg::OP_IDLE;
        end
    end

    // phase, tick and pin updates
    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        pins_next  = pins_reg;
        pins_pre   = pins_reg;
        if (is_cmd && !busy)
        begin
            phase_next     = '0;
            tick_next      = '0;
            pins_pre.drive = 1'b1;
            if (act == twisp_pkg::ACT_WRITE)
            begin
                pins_pre.shift = tx_byte;
            end
            if (act == twisp_pkg::ACT_READ)
            begin
                pins_pre.shift = '0;
                pins_pre.drive = 1'b0;
                pins_pre.sda   = 1'b0;
            end
            pins_next = enter_phase(op_cmd, '0, sda_in, pins_pre);
        end
        else if (is_tick && busy)
        begin
            if (phase_end)
            begin
                tick_next  = '0;
                pins_next  = enter_phase(op_reg, phase_inc, sda_in, pins_reg);
                phase_next = op_last ? '0 : phase_inc;
            end
            else
            begin
                tick_next = tick_inc;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg         <= twisp_pkg::OP_IDLE;
            phase_reg      <= '0;
            tick_reg       <= '0;
            pins_reg.shift <= '0;
            pins_reg.clk   <= 1'b0;
            pins_reg.sda   <= 1'b0;
            pins_reg.drive <= 1'b1;
            pins_reg.rx    <= '0;
        end
        else if (step_en)
        begin
            op_reg    <= op_next;
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            pins_reg  <= pins_next;
        end
    end

    // result of this step
    always_comb
    begin
        res.clk_level = pins_next.clk;
        res.sda_level = pins_next.drive & pins_next.sda;
        res.sda_drive = pins_next.drive;
        res.busy_res  = (op_next != twisp_pkg::OP_IDLE);
        res.done_res  = done_c;
        res.refused   = refused_c;
        res.rx_byte   = pins_next.rx;
    end

    // an idle sequencer sits at phase zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (op_reg == twisp_pkg::OP_IDLE) |-> (phase_reg == '0))
        else $error("phase index not cleared while idle");

    // phase index never runs past the longest operation
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg < twisp_pkg::XFER_PHASES)
        else $error("phase index out of range");

    // a finishing step leaves the sequencer idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && done_c) |=> (op_reg == twisp_pkg::OP_IDLE))
        else $error("operation still active after done");

    // refusal and completion never coincide
    assert property (@(posedge clk) disable iff (!rst_n)
        step_en |-> !(refused_c && done_c))
        else $error("refused and done in one step");

endmodule

`default_nettype wire

[tb/sv/tb_two_wire_isp_frame_master_unit.sv]
// Testbench for the two-wire programming link master: random and directed commands and ticks
// against a cycle-free predictor held in a small scoreboard class.
// Depends on twisp_pkg and two_wire_isp_frame_master_unit.
`timescale 1ns / 1ps

import twisp_pkg::*;

// predicts the pin state after every input transaction and checks each result
class frame_scoreboard;
    result_t          expected_q[$];
    op_t              busy_op;
    logic [4:0]       phase_no;
    logic [7:0]       hold_cnt;
    logic [7:0]       shifter;
    logic [7:0]       last_rx;
    logic [7:0]       half_ticks;
    logic             pin_clk;
    logic             pin_sda;
    logic             pin_drv;
    int               errors;
    int               checked;
    int               finished;
    int               refusals;
    int               work_items;

    function new();
        busy_op    = OP_IDLE;
        phase_no   = '0;
        hold_cnt   = '0;
        shifter    = '0;
        last_rx    = '0;
        half_ticks = HALF_PERIOD_RESET;
        pin_clk    = 1'b0;
        pin_sda    = 1'b0;
        pin_drv    = 1'b1;
        errors     = 0;
        checked    = 0;
        finished   = 0;
        refusals   = 0;
        work_items = 0;
    endfunction

    function void set_half(logic [7:0] v);
        half_ticks = v;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function bit is_busy();
        return busy_op != OP_IDLE;
    endfunction

    // number of the phase on which an operation completes
    function logic [4:0] final_phase(op_t op);
        case (op)
            OP_START: return START_PHASES;
            OP_WRITE: return XFER_PHASES;
            OP_READ:  return XFER_PHASES;
            OP_END:   return END_PHASES;
            default:  return '0;
        endcase
    endfunction

    // pin changes on entering the current phase
    function void apply_phase(logic bit_in);
        case (busy_op)
            OP_START:
            begin
                case (phase_no)
                    5'd0: pin_sda = 1'b1;
                    5'd1: pin_clk = 1'b1;
                    5'd2: pin_sda = 1'b0;
                    5'd3: pin_clk = 1'b0;
                    default: ;
                endcase
            end
            OP_WRITE:
            begin
                if (phase_no < BIT_PHASES)
                begin
                    if (!phase_no[0])
                    begin
                        if (phase_no != '0)
                            shifter = {shifter[6:0], 1'b0};
                        pin_clk = 1'b0;
                        pin_sda = shifter[7];
                    end
                    else
                        pin_clk = 1'b1;
                end
                else if (phase_no == BIT_PHASES)
                    pin_clk = 1'b0;
                else
                    pin_sda = 1'b0;
            end
            OP_READ:
            begin
                if (phase_no < BIT_PHASES)
                begin
                    if (!phase_no[0])
                        pin_clk = 1'b0;
                    else
                    begin
                        pin_clk = 1'b1;
                        shifter = {shifter[6:0], bit_in};
                    end
                end
                else if (phase_no == BIT_PHASES)
                    pin_clk = 1'b0;
                else
                begin
                    pin_drv = 1'b1;
                    pin_sda = 1'b0;
                    last_rx = shifter;
                end
            end
            OP_END:
            begin
                case (phase_no)
                    5'd0: pin_clk = 1'b0;
                    5'd1: pin_sda = 1'b0;
                    5'd2: pin_clk = 1'b1;
                    default: pin_sda = 1'b1;
                endcase
            end
            default: ;
        endcase
    endfunction

    // advance the predicted state by one accepted input transaction
    function void note_input(logic [2:0] act, logic [7:0] tx, logic bit_in);
        result_t r;
        logic    done;
        logic    refd;
        done = 1'b0;
        refd = 1'b0;
        if (act >= ACT_START && act <= ACT_END)
        begin
            if (busy_op != OP_IDLE)
            begin
                refd = 1'b1;
                refusals++;
            end
            else
            begin
                busy_op  = op_t'(act);
                phase_no = '0;
                hold_cnt = '0;
                pin_drv  = 1'b1;
                if (act == ACT_WRITE)
                    shifter = tx;
                if (act == ACT_READ)
                begin
                    shifter = '0;
                    pin_drv = 1'b0;
                    pin_sda = 1'b0;
                end
                apply_phase(bit_in);
                work_items++;
            end
        end
        else if (act == ACT_TICK && busy_op != OP_IDLE)
        begin
            work_items++;
            hold_cnt = hold_cnt + 8'd1;
            if (hold_cnt >= half_ticks)
            begin
                hold_cnt = '0;
                phase_no = phase_no + 5'd1;
                apply_phase(bit_in);
                if (phase_no >= final_phase(busy_op))
                begin
                    done     = 1'b1;
                    busy_op  = OP_IDLE;
                    phase_no = '0;
                    finished++;
                end
            end
        end
        r.clk_level = pin_clk;
        r.sda_level = pin_drv ? pin_sda : 1'b0;
        r.sda_drive = pin_drv;
        r.busy_res  = (busy_op != OP_IDLE);
        r.done_res  = done;
        r.refused   = refd;
        r.rx_byte   = last_rx;
        expected_q.push_back(r);
    endfunction

    task flag(string msg);
        if (errors < 20)
            $display("mismatch: %s", msg);
        errors++;
    endtask

    task match_field(string name, int unsigned got, int unsigned want);
        if (got != want)
            flag($sformatf("result %0d %s got %0h expected %0h", checked, name, got, want));
    endtask

    // compare one result transaction with the oldest prediction
    task check_result(result_t got);
        result_t want;
        if (expected_q.size() == 0)
        begin
            flag($sformatf("result %0d arrived with nothing expected", checked));
            checked++;
            return;
        end
        want = expected_q.pop_front();
        match_field("clk_level", got.clk_level, want.clk_level);
        match_field("sda_level", got.sda_level, want.sda_level);
        match_field("sda_drive", got.sda_drive, want.sda_drive);
        match_field("busy_res", got.busy_res, want.busy_res);
        match_field("done_res", got.done_res, want.done_res);
        match_field("refused", got.refused, want.refused);
        match_field("rx_byte", got.rx_byte, want.rx_byte);
        checked++;
    endtask
endclass

module tb_two_wire_isp_frame_master_unit;

    localparam logic [2:0] ACT_TOP = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [HALF_W-1:0]     cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [2:0]            action = ACT_TICK;
    logic [BYTE_W-1:0]     tx_byte = '0;
    logic                  sda_in = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  clk_level;
    logic                  sda_level;
    logic                  sda_drive;
    logic                  busy_res;
    logic                  done_res;
    logic                  refused;
    logic [BYTE_W-1:0]     rx_byte;

    result_t               seen;
    frame_scoreboard       sb;
    logic [8:0]            stall_phase = '0;
    int                    burst_left = 0;
    int                    frame_pos = 0;
    int                    frame_bytes = 2;
    int                    odd_codes = 0;

    two_wire_isp_frame_master_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .tx_byte   (tx_byte),
        .sda_in    (sda_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .clk_level (clk_level),
        .sda_level (sda_level),
        .sda_drive (sda_drive),
        .busy_res  (busy_res),
        .done_res  (done_res),
        .refused   (refused),
        .rx_byte   (rx_byte)
    );

    assign seen = {clk_level, sda_level, sda_drive, busy_res, done_res, refused, rx_byte};

    // clock
    always #5 clk = ~clk;

    // result side: check accepted transactions, stall in four rotating modes
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(seen);
        stall_phase <= stall_phase + 9'd1;
        case (stall_phase[8:7])
            2'd0: out_ready <= 1'b1;
            2'd1: out_ready <= ($urandom_range(3, 0) != 0);
            2'd2: out_ready <= stall_phase[1];
            default: out_ready <= ($urandom_range(7, 0) == 0);
        endcase
    end

    // offer one input transaction and wait for it to be taken
    task send_item(logic [2:0] act, logic [7:0] tx, logic bit_in);
        in_valid <= 1'b1;
        action   <= act;
        tx_byte  <= tx;
        sda_in   <= bit_in;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        if (act > ACT_END)
            odd_codes++;
        sb.note_input(act, tx, bit_in);
    endtask

    // bursts of random length separated by random gaps
    task pace();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
            burst_left = ($urandom_range(9, 0) == 0) ? 60 : $urandom_range(12, 1);
        end
    endtask

    // hold off until every predicted result has been taken
    task drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task write_half(logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        sb.set_half(v);
        cfg_valid <= 1'b0;
        repeat (2) @(posedge clk);
    endtask

    function logic [7:0] pick_byte();
        case ($urandom_range(5, 0))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255, 0));
        endcase
    endfunction

    // mostly well-formed frames (start, bytes, end) driven by ticks, plus noise
    task run_phase(int target);
        int         base;
        int         roll;
        logic [2:0] act;
        base = sb.work_items;
        while (sb.work_items - base < target)
        begin
            roll = $urandom_range(99, 0);
            if (sb.is_busy())
            begin
                if (roll < 6)
                    act = 3'($urandom_range(ACT_END, ACT_START));
                else if (roll < 9)
                    act = 3'($urandom_range(ACT_TOP, ACT_END + 1));
                else
                    act = ACT_TICK;
            end
            else if (roll < 8)
                act = ACT_TICK;
            else if (roll < 12)
                act = 3'($urandom_range(ACT_TOP, ACT_END + 1));
            else if (roll < 20)
                act = 3'($urandom_range(ACT_END, ACT_START));
            else if (frame_pos == 0)
            begin
                act = ACT_START;
                frame_pos = 1;
            end
            else if (frame_pos <= frame_bytes)
            begin
                act = $urandom_range(1, 0) ? ACT_WRITE : ACT_READ;
                frame_pos++;
            end
            else
            begin
                act = ACT_END;
                frame_pos = 0;
                frame_bytes = $urandom_range(4, 1);
            end
            send_item(act, pick_byte(), 1'($urandom_range(1, 0)));
            pace();
        end
    endtask

    // stimulus
    initial
    begin
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset half period: idle tick, unused codes, a start with a refused write on the way
        send_item(ACT_TICK, 8'h00, 1'b1);
        send_item(ACT_TOP, 8'hFF, 1'b0);
        send_item(ACT_START, 8'h00, 1'b0);
        send_item(ACT_WRITE, 8'hFF, 1'b1);
        send_item(3'(ACT_END + 1), 8'h00, 1'b0);
        repeat (8) send_item(ACT_TICK, 8'h00, 1'b0);

        // zero half period behaves as one
        drain();
        write_half(8'd0);
        send_item(ACT_END, 8'h5A, 1'b1);
        repeat (3) send_item(ACT_TICK, 8'h00, 1'b1);

        // random part over several half periods, extremes included
        drain();
        write_half(8'd1);
        run_phase(100);
        drain();
        run_phase(100);
        drain();
        write_half(8'd3);
        run_phase(150);
        drain();
        write_half(8'd255);
        run_phase(1040);
        drain();
        write_half(8'd2);
        run_phase(100);
        drain();
        write_half(8'($urandom_range(9, 4)));
        run_phase(100);
        drain();
        write_half(8'd0);
        run_phase(100);

        // final wait for outstanding results
        drain();
        repeat (5) @(posedge clk);
        if (sb.pending() != 0)
            sb.flag($sformatf("%0d results never arrived", sb.pending()));
        $display("checked %0d result transactions: %0d commands completed, %0d refused",
                 sb.checked, sb.finished, sb.refusals);
        $display("%0d unused action codes sent, half periods 0, 1, 2, 3, 255 and one random",
                 odd_codes);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
